// ===== hdl/mtad_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the multi-tap audio delay.
// No dependencies; imported by the controller, the datapath and the top level.
package mtad_pkg;

   // Configuration register map (word index = paddr[3:2])
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_TAP_COUNT     = 2'd0;
   localparam logic [1:0] REG_DELAY_SAMPLES = 2'd1;
   localparam logic [1:0] REG_WET_MIX       = 2'd2;
   localparam logic [1:0] REG_FEEDBACK_MODE = 2'd3;

   localparam int TAP_COUNT_W = 3;
   localparam int DELAY_W     = 13;
   localparam int MIX_W       = 17;

   localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET     = 3'd1;
   localparam logic [DELAY_W-1:0]     DELAY_SAMPLES_RESET = 13'd2400;
   localparam logic [MIX_W-1:0]       WET_MIX_RESET       = 17'd39322;

   // Fixed point: accumulator in units of 2^-16 sample LSB
   localparam int FRAC_BITS  = 16;
   localparam int HALF_SHIFT = 15;
   localparam int ROUND_HALF = 32768;
   localparam logic [MIX_W-1:0] MIX_ONE = 17'd65536;

   // gain_j = floor(mix / (j+2)) = (mix * RECIP_TABLE[j]) >> RECIP_SHIFT,
   // exact for mix <= 2^16 and divisors up to 11
   localparam int GAIN_W      = 17;
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_DEPTH = 10;
   localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_DEPTH] = '{
      24'd8388608, 24'd5592406, 24'd4194304, 24'd3355444, 24'd2796203,
      24'd2396746, 24'd2097152, 24'd1864136, 24'd1677722, 24'd1525202
   };

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_MAC,
      ST_ACC,
      ST_WRITE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic start;
      logic addr;
      logic read;
      logic mac;
      logic acc;
      logic write;
      logic load_out;
   } mtad_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic no_taps;
      logic last_tap;
      logic out_free;
   } mtad_status_type;

endpackage

// ===== hdl/mtad_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the multi-tap audio delay: clear pass, then per-tap steps.
// Depends on mtad_pkg for the state, command and status types.
module mtad_ctrl
   import mtad_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  mtad_status_type status,
   output mtad_cmd_type    cmd,
   output state_type       state
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = status.no_taps ? ST_FINISH : ST_ADDR;
            end
         end
         ST_ADDR: begin
            cmd.addr = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = status.last_tap ? ST_FINISH : ST_ADDR;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign state = state_ff;

endmodule

// ===== hdl/mtad_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the multi-tap audio delay: delay memory, tap pointers,
// gain multiply, accumulator, rounding/saturation and the result register.
// Depends on mtad_pkg; driven by mtad_ctrl commands.
module mtad_datapath
   import mtad_pkg::*;
#(
   parameter int MAX_TAPS    = 4,
   parameter int MAX_DELAY   = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mtad_cmd_type                  cmd,
   output mtad_status_type               status,
   input  logic [TAP_COUNT_W-1:0]        tap_count,
   input  logic [DELAY_W-1:0]            delay_samples,
   input  logic [MIX_W-1:0]              wet_mix,
   input  logic                          feedback_mode,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] sample_out,
   output logic                          clipped
);

   localparam int SB          = SAMPLE_BITS;
   localparam int STORE_DEPTH = (MAX_TAPS * (MAX_TAPS + 1) / 2) * MAX_DELAY;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LEN_W       = $clog2(MAX_TAPS * MAX_DELAY + 1);
   localparam int TAP_W       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int TCNT_W      = $clog2(MAX_TAPS + 1);
   localparam int ACC_W       = SB + 20;
   localparam int PROD_W      = GAIN_W + 1 + SB;
   localparam int QW          = ACC_W + 1 - FRAC_BITS;

   // Round to nearest (ties up), then saturate; returns {saturated, value}
   function automatic logic [SB:0] round_sat(input logic signed [ACC_W-1:0] a);
      logic signed [ACC_W:0] r;
      logic [QW-1:0]         q;
      logic [SB:0]           res;
      r = $signed({a[ACC_W-1], a}) + $signed({1'b0, ACC_W'(ROUND_HALF)});
      q = r[ACC_W:FRAC_BITS];
      if (!q[QW-1] && (|q[QW-2:SB-1])) begin
         res = {1'b1, 1'b0, {(SB-1){1'b1}}};
      end else if (q[QW-1] && !(&q[QW-2:SB-1])) begin
         res = {1'b1, 1'b1, {(SB-1){1'b0}}};
      end else begin
         res = {1'b0, q[SB-1:0]};
      end
      return res;
   endfunction

   // Delay memory, no reset: cleared by the sweep after reset
   logic signed [SB-1:0] mem_ram [STORE_DEPTH];
   logic signed [SB-1:0] rdata_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic signed [SB-1:0] mem_wdata;

   logic [ADDR_W-1:0] clear_cnt_ff;
   logic [LEN_W-1:0]  pos_ff [MAX_TAPS];

   logic [TAP_W-1:0]        tap_ff;
   logic [ADDR_W-1:0]       offset_ff;
   logic [LEN_W-1:0]        incr_ff;
   logic [LEN_W-1:0]        len_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic [LEN_W-1:0]        pos_use_ff;
   logic [GAIN_W-1:0]       gain_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [SB-1:0]    x_ff;
   logic                    rsp_valid_ff;
   logic signed [SB-1:0]    sample_out_ff;
   logic                    clipped_ff;

   // Effective configuration
   logic [TCNT_W-1:0] taps_eff;
   logic [LEN_W-1:0]  base_eff;
   logic [MIX_W-1:0]  mix_eff;

   always_comb begin
      if (32'(tap_count) > 32'(MAX_TAPS)) begin
         taps_eff = TCNT_W'(MAX_TAPS);
      end else begin
         taps_eff = TCNT_W'(tap_count);
      end
      if (delay_samples == '0) begin
         base_eff = LEN_W'(1);
      end else if (32'(delay_samples) > 32'(MAX_DELAY)) begin
         base_eff = LEN_W'(MAX_DELAY);
      end else begin
         base_eff = LEN_W'(delay_samples);
      end
      mix_eff = (wet_mix > MIX_ONE) ? MIX_ONE : wet_mix;
   end

   logic [LEN_W-1:0]                cur_pos;
   logic [LEN_W-1:0]                pos_eff;
   logic [ADDR_W-1:0]               addr_in;
   logic [MIX_W+RECIP_W-1:0]        gain_prod;
   logic [GAIN_W-1:0]               gain_in;
   logic signed [PROD_W-1:0]        prod_in;
   logic signed [ACC_W-1:0]         acc_start;
   logic [LEN_W-1:0]                pos_next;
   logic [SB:0]                     tap_rs;
   logic [SB:0]                     out_rs;

   always_comb begin
      cur_pos   = pos_ff[tap_ff];
      // a line shortened by a config change restarts at its head
      pos_eff   = (cur_pos >= len_ff) ? '0 : cur_pos;
      addr_in   = ADDR_W'(32'(offset_ff) + 32'(pos_eff));
      gain_prod = mix_eff * RECIP_TABLE[tap_ff];
      gain_in   = gain_prod[RECIP_SHIFT+GAIN_W-1:RECIP_SHIFT];
      prod_in   = $signed({1'b0, gain_ff}) * rdata_ff;
      acc_start = {{(ACC_W-SB-HALF_SHIFT){sample_in[SB-1]}}, sample_in,
                   {HALF_SHIFT{1'b0}}};
      if (32'(pos_use_ff) + 32'd1 >= 32'(len_ff)) begin
         pos_next = '0;
      end else begin
         pos_next = LEN_W'(32'(pos_use_ff) + 32'd1);
      end
      tap_rs = round_sat(acc_ff);
      out_rs = round_sat(acc_ff);
   end

   always_comb begin
      mem_we    = cmd.clear_step | cmd.write;
      mem_waddr = cmd.clear_step ? clear_cnt_ff : addr_ff;
      if (cmd.clear_step) begin
         mem_wdata = '0;
      end else if (feedback_mode) begin
         mem_wdata = $signed(tap_rs[SB-1:0]);
      end else begin
         mem_wdata = x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
      if (cmd.read) begin
         rdata_ff <= mem_ram[addr_ff];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_TAPS; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         if (cmd.clear_step) begin
            clear_cnt_ff <= ADDR_W'(32'(clear_cnt_ff) + 32'd1);
         end
         if (cmd.write) begin
            pos_ff[tap_ff] <= pos_next;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         x_ff      <= sample_in;
         acc_ff    <= acc_start;
         tap_ff    <= '0;
         offset_ff <= '0;
         incr_ff   <= LEN_W'(MAX_DELAY);
         len_ff    <= base_eff;
      end
      if (cmd.addr) begin
         addr_ff    <= addr_in;
         pos_use_ff <= pos_eff;
         gain_ff    <= gain_in;
      end
      if (cmd.mac) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.write) begin
         tap_ff    <= TAP_W'(32'(tap_ff) + 32'd1);
         offset_ff <= ADDR_W'(32'(offset_ff) + 32'(incr_ff));
         incr_ff   <= LEN_W'(32'(incr_ff) + 32'(MAX_DELAY));
         len_ff    <= LEN_W'(32'(len_ff) + 32'(base_eff));
      end
      if (cmd.load_out) begin
         sample_out_ff <= $signed(out_rs[SB-1:0]);
         clipped_ff    <= out_rs[SB];
      end
   end

   always_comb begin
      status.clear_last = (clear_cnt_ff == ADDR_W'(STORE_DEPTH - 1));
      status.no_taps    = (taps_eff == '0);
      status.last_tap   = (32'(tap_ff) + 32'd1 == 32'(taps_eff));
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign sample_out = sample_out_ff;
   assign clipped    = clipped_ff;

endmodule

// ===== hdl/multi_tap_audio_delay.sv =====
`timescale 1ns / 1ps
// Multi-tap delay / echo effect, one signed PCM sample in, one sample out.
// Input: req_valid/req_ready with req_sample_in. Output: rsp_valid/rsp_ready
// with rsp_sample_out and rsp_clipped (set when the output was saturated).
// Configuration: APB-style csr_ port, registers tap_count (0x0),
// delay_samples (0x4), wet_mix (0x8), feedback_mode (0xC); pready is tied high.
// Write configuration only while no transaction is in flight.
// Samples are processed one at a time: a new input is taken only after the
// previous result is loaded; each tap takes address, memory read, multiply,
// accumulate and write-back steps through the single-port delay memory.
// Reset: a clearing pass zeroes the delay memory, one word per cycle, all
// MAX_TAPS*(MAX_TAPS+1)/2*MAX_DELAY words (40960 by default); req_ready stays
// low until it is done. Registers may be written during the pass.
// Stall: a finished result waits in the output register; the next input is
// taken meanwhile and its processing holds before write-out until rsp_ready.
// Depends on mtad_pkg, mtad_ctrl and mtad_datapath.
module multi_tap_audio_delay
   import mtad_pkg::*;
#(
   parameter int MAX_TAPS    = 4,
   parameter int MAX_DELAY   = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_clipped,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   logic [TAP_COUNT_W-1:0] tap_count_ff;
   logic [TAP_COUNT_W-1:0] tap_count_in;
   logic [DELAY_W-1:0]     delay_samples_ff;
   logic [DELAY_W-1:0]     delay_samples_in;
   logic [MIX_W-1:0]       wet_mix_ff;
   logic [MIX_W-1:0]       wet_mix_in;
   logic                   feedback_mode_ff;
   logic                   feedback_mode_in;

   logic       csr_write;
   logic [1:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      tap_count_in     = tap_count_ff;
      delay_samples_in = delay_samples_ff;
      wet_mix_in       = wet_mix_ff;
      feedback_mode_in = feedback_mode_ff;
      if (csr_write) begin
         case (csr_index)
            REG_TAP_COUNT:     tap_count_in     = csr_pwdata[TAP_COUNT_W-1:0];
            REG_DELAY_SAMPLES: delay_samples_in = csr_pwdata[DELAY_W-1:0];
            REG_WET_MIX:       wet_mix_in       = csr_pwdata[MIX_W-1:0];
            REG_FEEDBACK_MODE: feedback_mode_in = csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= TAP_COUNT_RESET;
         delay_samples_ff <= DELAY_SAMPLES_RESET;
         wet_mix_ff       <= WET_MIX_RESET;
         feedback_mode_ff <= 1'b0;
      end else begin
         tap_count_ff     <= tap_count_in;
         delay_samples_ff <= delay_samples_in;
         wet_mix_ff       <= wet_mix_in;
         feedback_mode_ff <= feedback_mode_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_TAP_COUNT:     csr_prdata = CSR_DATA_W'(tap_count_ff);
         REG_DELAY_SAMPLES: csr_prdata = CSR_DATA_W'(delay_samples_ff);
         REG_WET_MIX:       csr_prdata = CSR_DATA_W'(wet_mix_ff);
         REG_FEEDBACK_MODE: csr_prdata = CSR_DATA_W'(feedback_mode_ff);
         default:           csr_prdata = '0;
      endcase
   end

   mtad_cmd_type    cmd;
   mtad_status_type status;
   state_type       ctl_state;

   mtad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd),
      .state     (ctl_state)
   );

   mtad_datapath #(
      .MAX_TAPS    (MAX_TAPS),
      .MAX_DELAY   (MAX_DELAY),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .tap_count     (tap_count_ff),
      .delay_samples (delay_samples_ff),
      .wet_mix       (wet_mix_ff),
      .feedback_mode (feedback_mode_ff),
      .sample_in     (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .sample_out    (rsp_sample_out),
      .clipped       (rsp_clipped)
   );

   // An accepted transaction always moves the sequencer out of idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (ctl_state != ST_IDLE))
      else $error("sequencer stayed idle after accepting a transaction");

   // A result only appears after the finish step
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(ctl_state) == ST_FINISH))
      else $error("rsp_valid rose without a finish step");

   // Nothing is produced while the memory is being cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (ctl_state == ST_CLEAR) |-> !rsp_valid)
      else $error("result valid during clearing pass");

endmodule
